// File: rtl/core/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

// File: rtl/core/smdf_pkg.sv
package smdf_pkg;

   localparam int WINDOW = 9;
   localparam int DATA_W = 16;
   localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W  = $clog2(WINDOW + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_LOAD,
      ST_SCAN,
      ST_CHECK,
      ST_OUTPUT
   } state_type;

   // control from the sequencer to the rank unit
   typedef struct packed {
      logic load;
      logic acc;
   } rank_ctl_type;

endpackage

// File: rtl/core/smdf_ram.sv
module smdf_ram #(
   parameter  int WIDTH  = 16,
   parameter  int DEPTH  = 9,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/core/smdf_rank.sv
module smdf_rank (
   input  logic                        clock,
   input  smdf_pkg::rank_ctl_type      ctl,
   input  logic [smdf_pkg::DATA_W-1:0] rdata,
   output logic [smdf_pkg::DATA_W-1:0] cand,
   output logic [smdf_pkg::CNT_W-1:0]  less,
   output logic [smdf_pkg::CNT_W-1:0]  eq
);

   logic [smdf_pkg::DATA_W-1:0] cand_ff, cand_in;
   logic [smdf_pkg::CNT_W-1:0]  less_ff, less_in;
   logic [smdf_pkg::CNT_W-1:0]  eq_ff, eq_in;

   // one signed comparator shared over every candidate and every entry
   always_comb begin
      cand_in = cand_ff;
      less_in = less_ff;
      eq_in   = eq_ff;
      if (ctl.load) begin
         cand_in = rdata;
         less_in = '0;
         eq_in   = '0;
      end else if (ctl.acc) begin
         if ($signed(rdata) < $signed(cand_ff)) begin
            less_in = less_ff + smdf_pkg::CNT_W'(1);
         end else if (rdata == cand_ff) begin
            eq_in = eq_ff + smdf_pkg::CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      cand_ff <= cand_in;
      less_ff <= less_in;
      eq_ff   <= eq_in;
   end

   assign cand = cand_ff;
   assign less = less_ff;
   assign eq   = eq_ff;

endmodule

// File: rtl/core/sliding_median_distance_filter.sv
// sliding window median of signed distance estimates
// req channel: one beat carries req_distance_mm; it is accepted when req_valid is
//   high and req_stall is low, and req_stall stays high while a beat is in work
// rsp channel: one beat per request with rsp_median_mm and rsp_samples_used,
//   held in an output register until taken (rsp_valid high, rsp_stall low)
// the sample lands in a ring of the last WINDOW beats kept in a small ram; the
//   median comes from ranking: each stored entry is loaded as a candidate, then
//   one comparator walks all n entries counting smaller and equal ones
// for n stored samples the sequencer takes each entry in turn as the candidate:
//   it reads it, loads it, scans all n entries and checks its rank; after the last
//   candidate the output step registers the result; the single ram read port and
//   the shared comparator set this
// a new request is taken while the previous result still waits on rsp
// an even count gives the mean of the two middle values, truncated toward zero
// when a previous result still waits and rsp stalls the finished result holds the sequencer in its output step
// reset empties the window (count and write slot to zero) and drops any result;
//   ring contents are not cleared since only written slots are ever read
`include "assert_macros.svh"

module sliding_median_distance_filter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_distance_mm,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_median_mm,
   output logic [3:0]  rsp_samples_used
);

   localparam int SW = smdf_pkg::SLOT_W;
   localparam int CW = smdf_pkg::CNT_W;
   localparam int DW = smdf_pkg::DATA_W;

   smdf_pkg::state_type state_ff, state_in;

   logic [SW-1:0] wslot_ff, wslot_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] i_ff, i_in;          // candidate index
   logic [CW-1:0] j_ff, j_in;          // next entry to read in the scan
   logic [DW-1:0] lo_ff, lo_in;        // lower middle value
   logic [DW-1:0] hi_ff, hi_in;        // upper middle value
   logic          rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0] rsp_median_ff, rsp_median_in;
   logic [3:0]    rsp_used_ff, rsp_used_in;

   logic                   req_fire;
   logic [SW-1:0]          raddr;
   logic [DW-1:0]          rdata;
   smdf_pkg::rank_ctl_type rank_ctl;
   logic [DW-1:0]          rank_cand;
   logic [CW-1:0]          rank_less;
   logic [CW-1:0]          rank_eq;

   // rank positions of the two middle values
   logic [CW-1:0] k_lo, k_hi;
   logic [CW:0]   rank_top;
   logic          hit_lo, hit_hi;
   logic          out_free;
   logic [DW:0]   mid_sum, mid_adj;

   assign req_stall = (state_ff != smdf_pkg::ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   smdf_ram #(
      .WIDTH(DW),
      .DEPTH(smdf_pkg::WINDOW)
   ) u_ring (
      .clock(clock),
      .we   (req_fire),
      .waddr(wslot_ff),
      .wdata(req_distance_mm),
      .raddr(raddr),
      .rdata(rdata)
   );

   smdf_rank u_rank (
      .clock(clock),
      .ctl  (rank_ctl),
      .rdata(rdata),
      .cand (rank_cand),
      .less (rank_less),
      .eq   (rank_eq)
   );

   // candidate covers ranks less .. less+eq-1
   always_comb begin
      k_lo     = (count_ff - CW'(1)) >> 1;
      k_hi     = count_ff >> 1;
      rank_top = {1'b0, rank_less} + {1'b0, rank_eq};
      hit_lo   = (rank_less <= k_lo) && ({1'b0, k_lo} < rank_top);
      hit_hi   = (rank_less <= k_hi) && ({1'b0, k_hi} < rank_top);
   end

   // halve with truncation toward zero: bump negative sums by one first
   always_comb begin
      mid_sum = {lo_ff[DW-1], lo_ff} + {hi_ff[DW-1], hi_ff};
      mid_adj = mid_sum + (DW+1)'(mid_sum[DW]);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         smdf_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = smdf_pkg::ST_FETCH;
            end
         end
         smdf_pkg::ST_FETCH: begin
            state_in = smdf_pkg::ST_LOAD;
         end
         smdf_pkg::ST_LOAD: begin
            state_in = smdf_pkg::ST_SCAN;
         end
         smdf_pkg::ST_SCAN: begin
            if (j_ff >= count_ff) begin
               state_in = smdf_pkg::ST_CHECK;
            end
         end
         smdf_pkg::ST_CHECK: begin
            if ((i_ff + CW'(1)) < count_ff) begin
               state_in = smdf_pkg::ST_LOAD;
            end else begin
               state_in = smdf_pkg::ST_OUTPUT;
            end
         end
         smdf_pkg::ST_OUTPUT: begin
            if (out_free) begin
               state_in = smdf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = smdf_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath control
   always_comb begin
      wslot_in      = wslot_ff;
      count_in      = count_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      raddr         = i_ff[SW-1:0];
      rank_ctl      = '0;
      rsp_median_in = rsp_median_ff;
      rsp_used_in   = rsp_used_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      case (state_ff)
         smdf_pkg::ST_IDLE: begin
            if (req_fire) begin
               // ring write happens in the ram on this edge
               if (wslot_ff == SW'(smdf_pkg::WINDOW - 1)) begin
                  wslot_in = '0;
               end else begin
                  wslot_in = wslot_ff + SW'(1);
               end
               if (count_ff < CW'(smdf_pkg::WINDOW)) begin
                  count_in = count_ff + CW'(1);
               end
               i_in = '0;
            end
         end
         smdf_pkg::ST_FETCH: begin
            raddr = i_ff[SW-1:0];
         end
         smdf_pkg::ST_LOAD: begin
            rank_ctl.load = 1'b1;
            raddr         = '0;
            j_in          = CW'(1);
         end
         smdf_pkg::ST_SCAN: begin
            // data for entry j-1 is on the read port
            rank_ctl.acc = 1'b1;
            if (j_ff < count_ff) begin
               raddr = j_ff[SW-1:0];
               j_in  = j_ff + CW'(1);
            end
         end
         smdf_pkg::ST_CHECK: begin
            if (hit_lo) begin
               lo_in = rank_cand;
            end
            if (hit_hi) begin
               hi_in = rank_cand;
            end
            i_in  = i_ff + CW'(1);
            raddr = i_in[SW-1:0];
         end
         smdf_pkg::ST_OUTPUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_median_in = mid_adj[DW:1];
               rsp_used_in   = 4'(count_ff);
            end
         end
         default: begin
            rank_ctl = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= smdf_pkg::ST_IDLE;
         wslot_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wslot_ff     <= wslot_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff          <= i_in;
      j_ff          <= j_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      rsp_median_ff <= rsp_median_in;
      rsp_used_ff   <= rsp_used_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_median_mm    = rsp_median_ff;
   assign rsp_samples_used = rsp_used_ff;

   `ASSERT_IMPLIES(a_count_max, clock, reset, 1'b1,
      count_ff <= CW'(smdf_pkg::WINDOW), "count over window")
   `ASSERT_IMPLIES(a_self_match, clock, reset, state_ff == smdf_pkg::ST_CHECK,
      rank_eq != '0, "candidate missed itself")
   `ASSERT_NEXT(a_accept_fetch, clock, reset, req_fire,
      state_ff == smdf_pkg::ST_FETCH, "accept did not start fetch")
   `ASSERT_IMPLIES(a_rsp_source, clock, reset, $rose(rsp_valid_ff),
      $past(state_ff) == smdf_pkg::ST_OUTPUT, "result without output step")

endmodule

// File: bench/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // run shape
   localparam int RANDOM_BEATS = 1200;
   localparam int TAIL_BEATS   = 150;   // last stretch runs with no idling on either side
   localparam int PHASE_BEATS  = 150;   // idle density changes every this many beats
   localparam int DRAIN_CYCLES = 130;   // wait after the last result, longer than a full-window beat takes
   localparam int MAX_REPORTS  = 10;

   // idle density per phase
   localparam logic [1:0] IDLE_NONE  = 2'd0;
   localparam logic [1:0] IDLE_HEAVY = 2'd1;
   localparam logic [1:0] IDLE_LIGHT = 2'd2;

   typedef struct packed {
      logic signed [15:0] median_mm;
      logic [3:0]         samples_used;
   } median_rec_type;

   // block ports, every input known from time zero
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [15:0] req_distance_mm = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_median_mm;
   logic [3:0]  rsp_samples_used;

   // stimulus and scoreboard
   logic [15:0]    distance_backlog [$];
   median_rec_type expected_medians [$];
   int             total_beats = 0;
   int             corner_beats = 0;
   int             beats_sent = 0;
   int             medians_checked = 0;
   int             failures = 0;

   // idling control, written by the request driver and the back-pressure process only
   int          send_gap = 0;
   int          hold_left = 0;
   logic [1:0]  idle_phase = IDLE_HEAVY;
   logic        in_tail = 1'b0;

   // private copy of the window state
   logic signed [15:0] ring_mm [smdf_pkg::WINDOW];
   int                 ring_slot = 0;
   int                 ring_count = 0;

   sliding_median_distance_filter dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_distance_mm  (req_distance_mm),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_median_mm    (rsp_median_mm),
      .rsp_samples_used (rsp_samples_used)
   );

   // 20 ns clock
   initial begin
      forever #10 clock = ~clock;
   end

   // store one sample in the window and return the median the block should report
   function automatic median_rec_type median_after_insert(logic [15:0] raw);
      int             sorted_mm [smdf_pkg::WINDOW];
      int             n;
      int             i;
      int             j;
      int             key;
      int             med;
      median_rec_type rec;
      ring_mm[ring_slot] = raw;
      ring_slot = (ring_slot == smdf_pkg::WINDOW - 1) ? 0 : ring_slot + 1;
      if (ring_count < smdf_pkg::WINDOW) ring_count = ring_count + 1;
      n = ring_count;
      // only slots below the count have ever been written
      for (i = 0; i < n; i++) sorted_mm[i] = ring_mm[i];
      for (i = 1; i < n; i++) begin
         key = sorted_mm[i];
         j = i;
         while (j > 0 && sorted_mm[j - 1] > key) begin
            sorted_mm[j] = sorted_mm[j - 1];
            j = j - 1;
         end
         sorted_mm[j] = key;
      end
      // even count: mean of the middle pair, int division truncates toward zero
      if (n % 2 == 1) med = sorted_mm[n / 2];
      else med = (sorted_mm[n / 2 - 1] + sorted_mm[n / 2]) / 2;
      rec.median_mm = med[15:0];
      rec.samples_used = n[3:0];
      return rec;
   endfunction

   // request driver: presents backlog beats, holds them while stalled, idles in bursts
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_distance_mm <= '0;
         send_gap <= 0;
      end else begin
         in_tail <= (distance_backlog.size() < TAIL_BEATS);
         idle_phase <= 2'((beats_sent / PHASE_BEATS + 1) % 3);
         // the wire is free when nothing is shown or the shown beat goes through now
         if (!req_valid || !req_stall) begin
            if (req_valid) beats_sent <= beats_sent + 1;
            if (send_gap > 0) begin
               req_valid <= 1'b0;
               send_gap <= send_gap - 1;
            end else if (distance_backlog.size() > 0) begin
               req_valid <= 1'b1;
               req_distance_mm <= distance_backlog.pop_front();
               if (!in_tail && ((idle_phase == IDLE_HEAVY && $urandom_range(0, 1) == 0) ||
                                (idle_phase == IDLE_LIGHT && $urandom_range(0, 5) == 0))) begin
                  send_gap <= $urandom_range(1, 18);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response back-pressure in random bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!in_tail && ((idle_phase == IDLE_HEAVY && $urandom_range(0, 19) == 0) ||
                                (idle_phase == IDLE_LIGHT && $urandom_range(0, 59) == 0))) begin
         rsp_stall <= 1'b1;
         hold_left <= $urandom_range(0, 17);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // monitor: predict on every accepted request beat, check every accepted result beat
   always @(posedge clock) begin
      median_rec_type got;
      median_rec_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got.median_mm = rsp_median_mm;
            got.samples_used = rsp_samples_used;
            medians_checked = medians_checked + 1;
            if (expected_medians.size() == 0) begin
               if (failures < MAX_REPORTS)
                  $display("%0t: result beat with nothing pending: median %0d used %0d",
                           $realtime, got.median_mm, got.samples_used);
               failures = failures + 1;
            end else begin
               want = expected_medians.pop_front();
               if (got.median_mm !== want.median_mm ||
                   got.samples_used !== want.samples_used) begin
                  if (failures < MAX_REPORTS)
                     $display("%0t: mismatch: median %0d used %0d, expected median %0d used %0d",
                              $realtime, got.median_mm, got.samples_used,
                              want.median_mm, want.samples_used);
                  failures = failures + 1;
               end
            end
         end
         if (req_valid && !req_stall)
            expected_medians.push_back(median_after_insert(req_distance_mm));
      end
   end

   // stimulus, reset and end of run
   initial begin
      logic [15:0] corner_mm [22];
      logic [15:0] cluster_mm;
      logic [15:0] d;
      int          pick;
      int          k;

      // window fill walks every count 1..9; the even ones hit truncation toward zero
      // (-1.5 becomes -1) and a middle pair whose sum overflows 16 bits; the rest wraps
      // the write slot, overwrites the oldest entries and repeats equal samples
      corner_mm = '{16'h7fff, 16'h8000, 16'hffff, 16'hfffe, 16'h7fff, 16'h7ffe,
                    16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                    16'h8000, 16'h0000, 16'h0001, 16'h0001, 16'h0001, 16'hfff9,
                    16'h0003, 16'h8000, 16'h7fff, 16'h8001};
      foreach (corner_mm[i]) distance_backlog.push_back(corner_mm[i]);
      corner_beats = distance_backlog.size();

      cluster_mm = '0;
      for (k = 0; k < RANDOM_BEATS; k++) begin
         if (k % 40 == 0) cluster_mm = 16'($urandom);
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            d = 16'($urandom);
         end else if (pick < 75) begin
            // tight cluster, lots of equal and neighboring samples
            d = 16'(cluster_mm + $urandom_range(0, 3));
         end else if (pick < 88) begin
            case ($urandom_range(0, 5))
               0: begin
                  d = 16'h8000;
               end
               1: begin
                  d = 16'h7fff;
               end
               2: begin
                  d = 16'h0000;
               end
               3: begin
                  d = 16'hffff;
               end
               4: begin
                  d = 16'h0001;
               end
               default: begin
                  d = 16'h8001;
               end
            endcase
         end else if ($urandom_range(0, 1) == 0) begin
            d = 16'(16'h7fff - $urandom_range(0, 2));
         end else begin
            d = 16'(16'h8000 + $urandom_range(0, 2));
         end
         distance_backlog.push_back(d);
      end
      total_beats = distance_backlog.size();

      // synchronous reset, released on an edge
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (beats_sent < total_beats || expected_medians.size() != 0) @(posedge clock);
      // nothing more should come out once the block has had time to finish
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_medians.size() != 0) begin
         $display("%0d expected medians never arrived", expected_medians.size());
         failures = failures + expected_medians.size();
      end

      $display("run: %0d distance beats (%0d corner cases, then random), %0d medians compared",
               beats_sent, corner_beats, medians_checked);
      $display("window of %0d filled from empty and wrapped about %0d times, %0d failures",
               smdf_pkg::WINDOW, beats_sent / smdf_pkg::WINDOW, failures);
      if (failures == 0) begin
         $display("** sliding_median_distance_filter: PASSED **");
      end else begin
         $display("** sliding_median_distance_filter: FAILED **");
      end
      $finish;
   end

   // watchdog, several times the slowest legal run
   initial begin
      #25_000_000;
      $display("timeout after %0d of %0d beats", beats_sent, total_beats);
      $display("** sliding_median_distance_filter: FAILED **");
      $finish;
   end

endmodule

// File: sliding_median_distance_filter.f
+incdir+rtl/core
rtl/core/smdf_pkg.sv
rtl/core/smdf_ram.sv
rtl/core/smdf_rank.sv
rtl/core/sliding_median_distance_filter.sv
bench/tb.sv
